/* src/mmps_pkg.sv */
// shared constants for the multi motor pendulum sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mmps_pkg;
  localparam int unsigned MotorCount = 4;
  localparam int unsigned MotorW = (MotorCount > 1) ? $clog2(MotorCount) : 1;
  localparam logic [10:0] IdBase = 11'h140;
  localparam logic [7:0] OpMove = 8'hA4;
  localparam logic [7:0] OpAngle = 8'h92;
  localparam logic [7:0] OpState2 = 8'h9C;
  localparam logic [7:0] OpStatus = 8'h9A;
  localparam logic [31:0] ArriveTimeoutMs = 32'd6000;
  localparam logic [31:0] FastPollMs = 32'd100;
  localparam logic [31:0] StatusPollMs = 32'd3000;
  localparam logic [1:0] RegAmplitude = 2'd0;
  localparam logic [1:0] RegSpeedLimit = 2'd1;
  localparam logic [1:0] RegStagger = 2'd2;
endpackage
`default_nettype wire

/* src/multi_motor_pendulum_sequencer_unit.sv */
// multi motor pendulum sequencer: motor sweep, arrival check, polls
// depends on mmps_pkg
//
// channel   dir  handshake          payload
// s_axis    in   s_axis_t*          tdata {frame_data,frame_id}, tuser kind
// m_axis    out  m_axis_t*          tdata {cmd_data,cmd_id}, tlast last_of_run
// cfg       in   cfg_valid/ready    index, data
// a tick takes MotorCount motor steps, 3 poll steps and one flush step, one step
// per cycle unless the output stalls; a frame is handled in the idle state.
// a step that has to push a beat while the output register is held waits until
// the output drains. reset clears motor state (each motor starts high) and the time count.
`timescale 1ns / 1ps
`default_nettype none
module multi_motor_pendulum_sequencer_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [79:0] s_axis_tdata,  // frame_id[10:0], frame_data[74:11], pad
  input  wire         s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [79:0] m_axis_tdata,  // cmd_id[10:0], cmd_data[74:11], pad
  output logic        m_axis_tlast,  // last_of_run
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [19:0] cfg_data
);
  import mmps_pkg::*;

  localparam logic [1:0] StIdle = 2'd0, StMotor = 2'd1, StPoll = 2'd2, StDone = 2'd3;

  logic [1:0] st_q;
  logic [MotorW-1:0] mi_q;
  logic [1:0] pi_q;
  logic [19:0] amp_q;
  logic [15:0] spd_lim_q, stag_q;
  logic [31:0] now_q, delay_q;
  logic [MotorCount-1:0] started_q, high_q, wait_q, rts_q;
  logic [31:0] mstart_q [MotorCount];
  logic [31:0] due_q [MotorCount];
  logic [31:0] tgt_q [MotorCount];
  logic [31:0] act_q [MotorCount];
  logic [15:0] mspd_q [MotorCount];
  logic [MotorW-1:0] cur_q [3];
  logic [31:0] plast_q [3];
  logic [74:0] pend_q;       // last produced beat, held until a later one or end
  logic pend_v_q;
  logic out_v_q, out_last_q;
  logic [74:0] out_q;

  wire in_fire = s_axis_tvalid && s_axis_tready;
  wire [10:0] f_id = s_axis_tdata[10:0];
  wire [63:0] f_dat = s_axis_tdata[74:11];
  // output register can take a beat
  wire out_free = !out_v_q || m_axis_tready;

  assign s_axis_tready = (st_q == StIdle) && !pend_v_q;
  assign cfg_ready = (st_q == StIdle);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {5'd0, out_q};
  assign m_axis_tlast = out_last_q;

  // frame decode
  wire [11:0] idx_w = {1'b0, f_id} - {1'b0, IdBase} - 12'd1;
  wire id_ok = (f_id > IdBase) && ({1'b0, f_id} <= {1'b0, IdBase} + 12'(MotorCount));
  wire [55:0] raw = f_dat[63:8];
  logic [31:0] ang_sat;
  always_comb begin
    if (raw[55]) ang_sat = (&raw[55:31]) ? raw[31:0] : 32'h8000_0000;
    else ang_sat = (|raw[55:31]) ? 32'h7FFF_FFFF : raw[31:0];
  end

  // one motor step, shared across motors
  wire [31:0] amp32 = {12'd0, amp_q};
  wire [31:0] tgt_new = high_q[mi_q] ? amp32 : (32'd0 - amp32);
  wire [74:0] move_beat = {tgt_new, spd_lim_q, 8'd0, OpMove,
                           IdBase + 11'(mi_q) + 11'd1};
  wire [32:0] pdiff = {act_q[mi_q][31], act_q[mi_q]} - {tgt_q[mi_q][31], tgt_q[mi_q]};
  wire close = ($signed(pdiff) < 33'sd500) && ($signed(pdiff) > -33'sd500);
  wire slow = ($signed(mspd_q[mi_q]) < 16'sd15) && ($signed(mspd_q[mi_q]) > -16'sd15);
  wire late = (now_q - mstart_q[mi_q]) > ArriveTimeoutMs;
  wire start_go = !started_q[mi_q] && (now_q > delay_q);
  wire rts_go = started_q[mi_q] && rts_q[mi_q] && (now_q >= due_q[mi_q]);
  wire arrive = started_q[mi_q] && !rts_q[mi_q] && wait_q[mi_q] && ((close && slow) || late);

  logic [7:0] p_op;
  logic [31:0] p_gap;
  always_comb begin
    unique case (pi_q)
      2'd0: begin p_op = OpAngle; p_gap = FastPollMs; end
      2'd1: begin p_op = OpState2; p_gap = FastPollMs; end
      default: begin p_op = OpStatus; p_gap = StatusPollMs; end
    endcase
  end
  wire p_go = (now_q - plast_q[pi_q]) > p_gap;
  wire [74:0] poll_beat = {56'd0, p_op, IdBase + 11'(cur_q[pi_q]) + 11'd1};

  wire mk = (st_q == StMotor) && (start_go || rts_go);
  wire pk = (st_q == StPoll) && p_go;
  wire emit = mk || pk;
  // a new beat pushes the pending one out; stall if output is full
  wire step_en = !(emit && pend_v_q && !out_free) &&
                 !((st_q == StDone) && pend_v_q && !out_free);
  wire push = step_en && pend_v_q && (emit || st_q == StDone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; mi_q <= '0; pi_q <= '0;
      amp_q <= 20'd17000; spd_lim_q <= 16'd210; stag_q <= '0;
      now_q <= '0; delay_q <= '0;
      started_q <= '0; high_q <= '1; wait_q <= '0; rts_q <= '0;
      pend_v_q <= 1'b0; out_v_q <= 1'b0; out_last_q <= 1'b0;
      pend_q <= '0; out_q <= '0;
      for (int k = 0; k < MotorCount; k++) begin
        mstart_q[k] <= '0; due_q[k] <= '0; tgt_q[k] <= '0;
        act_q[k] <= '0; mspd_q[k] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        cur_q[k] <= '0; plast_q[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          RegAmplitude: amp_q <= cfg_data;
          RegSpeedLimit: spd_lim_q <= cfg_data[15:0];
          RegStagger: stag_q <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (st_q)
        StIdle: if (in_fire) begin
          if (!s_axis_tuser) begin
            now_q <= now_q + 32'd1; mi_q <= '0; delay_q <= '0; st_q <= StMotor;
          end else if (id_ok) begin
            if (f_dat[7:0] == OpAngle) act_q[idx_w[MotorW-1:0]] <= ang_sat;
            else if (f_dat[7:0] == OpMove || f_dat[7:0] == OpState2)
              mspd_q[idx_w[MotorW-1:0]] <= f_dat[47:32];
          end
        end
        StMotor: if (step_en) begin
          if (start_go) started_q[mi_q] <= 1'b1;
          if (rts_go) rts_q[mi_q] <= 1'b0;
          if (start_go || rts_go) begin
            tgt_q[mi_q] <= tgt_new; mstart_q[mi_q] <= now_q; wait_q[mi_q] <= 1'b1;
          end
          if (arrive) begin
            wait_q[mi_q] <= 1'b0; high_q[mi_q] <= !high_q[mi_q];
            rts_q[mi_q] <= 1'b1; due_q[mi_q] <= now_q + delay_q;
          end
          delay_q <= delay_q + {16'd0, stag_q};
          if (32'(mi_q) == MotorCount - 1) begin
            st_q <= StPoll; pi_q <= '0;
          end else mi_q <= mi_q + 1'b1;
        end
        StPoll: if (step_en) begin
          if (p_go) begin
            cur_q[pi_q] <= (32'(cur_q[pi_q]) == MotorCount - 1) ? '0 : cur_q[pi_q] + 1'b1;
            plast_q[pi_q] <= now_q;
          end
          if (pi_q == 2'd2) st_q <= StDone;
          else pi_q <= pi_q + 2'd1;
        end
        default: if (step_en) st_q <= StIdle;
      endcase
      if (push) begin
        out_q <= pend_q; out_v_q <= 1'b1; out_last_q <= (st_q == StDone);
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      if (step_en && emit) begin
        pend_q <= mk ? move_beat : poll_beat; pend_v_q <= 1'b1;
      end else if (push) begin
        pend_v_q <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !s_axis_tready) else $error("input taken while busy");
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIdle) |-> !pend_v_q) else $error("pending beat left in idle");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("beat dropped");
`endif
endmodule
`default_nettype wire

/* tb/tb_multi_motor_pendulum_sequencer_unit.sv */
// self-checking bench for the multi motor pendulum sequencer unit
// depends on mmps_pkg and multi_motor_pendulum_sequencer_unit
`timescale 1ns / 1ps
module tb_multi_motor_pendulum_sequencer_unit;
  import mmps_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned SettleCycles = 40;

  typedef struct packed {
    logic [10:0] id;
    logic [63:0] data;
    logic        last;
  } cmd_beat_t;

  typedef struct {
    bit          kind;
    bit [10:0]   id;
    bit [63:0]   data;
    bit          chk;
    bit [10:0]   exp_id;
    bit [63:0]   exp_data;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // frame_id[10:0], frame_data[74:11], pad
  logic        s_axis_tuser = 1'b0;  // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;  // cmd_id[10:0], cmd_data[74:11], pad
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  multi_motor_pendulum_sequencer_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the sequencer
  logic [19:0]        amp_reg;
  logic [15:0]        spd_lim_reg;
  logic [15:0]        stagger_reg;
  logic [31:0]        clock_ms;
  bit                 mot_started [MotorCount];
  bit                 mot_high [MotorCount];
  bit                 mot_waiting [MotorCount];
  bit                 mot_armed [MotorCount];
  logic [31:0]        mot_move_ms [MotorCount];
  logic [31:0]        mot_due_ms [MotorCount];
  logic signed [31:0] mot_target [MotorCount];
  logic signed [31:0] mot_angle [MotorCount];
  logic signed [15:0] mot_speed [MotorCount];
  logic [1:0]         poll_cur [3];
  logic [31:0]        poll_ms [3];

  cmd_beat_t pending_cmds [$];
  int        fails = 0;
  int        mode = 2;  // 0: receiver idles more, 1: sender idles more, 2: no idling
  int        hold_reqs = 0;

  function automatic void reset_shadow();
    amp_reg = 20'd17000;
    spd_lim_reg = 16'd210;
    stagger_reg = 16'd0;
    clock_ms = '0;
    for (int i = 0; i < MotorCount; i++) begin
      mot_started[i] = 0;
      mot_high[i] = 1;
      mot_waiting[i] = 0;
      mot_armed[i] = 0;
      mot_move_ms[i] = '0;
      mot_due_ms[i] = '0;
      mot_target[i] = '0;
      mot_angle[i] = '0;
      mot_speed[i] = '0;
    end
    for (int p = 0; p < 3; p++) begin
      poll_cur[p] = '0;
      poll_ms[p] = '0;
    end
  endfunction

  function automatic void queue_move(int i);
    logic signed [31:0] tgt;
    tgt = mot_high[i] ? $signed({12'd0, amp_reg}) : -$signed({12'd0, amp_reg});
    mot_target[i] = tgt;
    mot_move_ms[i] = clock_ms;
    mot_waiting[i] = 1;
    pending_cmds.push_back('{IdBase + 11'(i + 1), {tgt, spd_lim_reg, 8'h00, OpMove}, 1'b0});
  endfunction

  function automatic void take_reply(logic [10:0] id, logic [63:0] data);
    int          idx;
    logic [55:0] raw;
    logic [56:0] mag;
    if (id < IdBase + 11'd1 || id > IdBase + 11'(MotorCount)) return;
    idx = int'(id - IdBase) - 1;
    if (data[7:0] == OpAngle) begin
      raw = data[63:8];
      if (raw[55]) begin
        mag = 57'(1) << 56;
        mag = mag - {1'b0, raw};
        mot_angle[idx] = (mag > 57'h80000000) ? 32'sh80000000 : -$signed(mag[31:0]);
      end else begin
        mot_angle[idx] = (raw > 56'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(raw[31:0]);
      end
    end else if (data[7:0] == OpMove || data[7:0] == OpState2) begin
      mot_speed[idx] = $signed(data[47:32]);
    end
  endfunction

  function automatic void predict_tick();
    logic [7:0]  poll_op [3];
    logic [31:0] poll_gap [3];
    logic [31:0] delay;
    longint      diff;
    int          spd;
    int          n_prior;
    int          m;
    poll_op = '{OpAngle, OpState2, OpStatus};
    poll_gap = '{FastPollMs, FastPollMs, StatusPollMs};
    n_prior = pending_cmds.size();
    clock_ms = clock_ms + 32'd1;
    for (int i = 0; i < MotorCount; i++) begin
      delay = 32'(i) * {16'd0, stagger_reg};
      if (!mot_started[i]) begin
        if (clock_ms > delay) begin
          mot_started[i] = 1;
          queue_move(i);
        end
      end else if (mot_armed[i]) begin
        if (clock_ms >= mot_due_ms[i]) begin
          mot_armed[i] = 0;
          queue_move(i);
        end
      end else if (mot_waiting[i]) begin
        diff = longint'(mot_angle[i]) - longint'(mot_target[i]);
        if (diff < 0) diff = -diff;
        spd = int'(mot_speed[i]);
        if (spd < 0) spd = -spd;
        if ((diff < 500 && spd < 15) || (clock_ms - mot_move_ms[i]) > ArriveTimeoutMs) begin
          mot_waiting[i] = 0;
          mot_high[i] = !mot_high[i];
          mot_armed[i] = 1;
          mot_due_ms[i] = clock_ms + delay;
        end
      end
    end
    for (int p = 0; p < 3; p++) begin
      if ((clock_ms - poll_ms[p]) > poll_gap[p]) begin
        m = int'(poll_cur[p]) % MotorCount;
        pending_cmds.push_back('{IdBase + 11'(m + 1), {56'd0, poll_op[p]}, 1'b0});
        poll_cur[p] = 2'((m + 1) % MotorCount);
        poll_ms[p] = clock_ms;
      end
    end
    if (pending_cmds.size() > n_prior) pending_cmds[pending_cmds.size() - 1].last = 1'b1;
  endfunction

  function automatic int idle_pct(bit sender);
    if (mode == 0) return sender ? 37 : 56;
    if (mode == 1) return sender ? 56 : 37;
    return 0;
  endfunction

  // sender: predicts on offer, items go in order so that matches acceptance
  task automatic send_item(bit kind, logic [10:0] id, logic [63:0] data);
    if ($urandom_range(99) < idle_pct(1)) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    if (kind) take_reply(id, data);
    else predict_tick();
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {5'd0, data, id};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      RegAmplitude:  amp_reg = val;
      RegSpeedLimit: spd_lim_reg = val[15:0];
      RegStagger:    stagger_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_item();
    int          r;
    int          i;
    logic [63:0] d;
    logic signed [31:0] v;
    logic signed [15:0] s;
    r = $urandom_range(99);
    i = $urandom_range(MotorCount - 1);
    d = {$urandom, $urandom};
    if (r < 40) begin
      send_item(1'b0, 11'($urandom), d);
    end else if (r < 60) begin
      // angle reply close to where the motor is heading
      v = mot_target[i] + $signed($urandom_range(1400)) - 700;
      send_item(1'b1, IdBase + 11'(i + 1), {{24{v[31]}}, v, OpAngle});
    end else if (r < 75) begin
      s = 16'($urandom_range(40)) - 16'sd20;
      d[47:32] = s;
      d[7:0] = $urandom_range(1) ? OpMove : OpState2;
      send_item(1'b1, IdBase + 11'(i + 1), d);
    end else if (r < 85) begin
      d[7:0] = OpAngle;
      send_item(1'b1, IdBase + 11'(i + 1), d);
    end else if (r < 95) begin
      send_item(1'b1, 11'($urandom), d);
    end else begin
      d[7:0] = OpStatus;
      send_item(1'b1, IdBase + 11'(i + 1), d);
    end
  endtask

  stim_row_t dir_rows [22] = '{
    '{1'b0, 11'h000, 64'h0, 1'b1, 11'h141, 64'h0000_4268_00D2_00A4},
    '{1'b1, 11'h141, {56'h7FFFFFFFFFFFFF, 8'h92}, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h142, {56'h80000000000000, 8'h92}, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h143, {56'hFFFFFF80000000, 8'h92}, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h143, {56'hFFFFFF7FFFFFFF, 8'h92}, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h144, {56'h0000007FFFFFFF, 8'h92}, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h142, 64'hFFFF_8000_FFFF_FF9C, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h143, 64'h0000_7FFF_0000_00A4, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h140, 64'h0000_0000_0000_0092, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h145, 64'h0000_0000_0000_009C, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h7FF, 64'hFFFF_FFFF_FFFF_FF92, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h141, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h141, 64'h1234_5678_9ABC_DE9A, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h141, 64'h0000_0000_0000_00FF, 1'b0, 11'h0, 64'h0},
    '{1'b0, 11'h000, 64'h0, 1'b0, 11'h0, 64'h0},
    // motor 1 lands near +170 deg at rest
    '{1'b1, 11'h141, {56'h000000000040D8, 8'h92}, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h141, 64'h0000_FFF2_0000_009C, 1'b0, 11'h0, 64'h0},
    '{1'b0, 11'h000, 64'h0, 1'b0, 11'h0, 64'h0},
    '{1'b0, 11'h000, 64'h0, 1'b1, 11'h141, 64'hFFFF_BD98_00D2_00A4},
    '{1'b1, 11'h144, {56'hFFFFFFFFFFBD98, 8'h92}, 1'b0, 11'h0, 64'h0},
    '{1'b1, 11'h144, 64'h0000_0000_0000_00A4, 1'b0, 11'h0, 64'h0},
    '{1'b0, 11'h000, 64'h0, 1'b0, 11'h0, 64'h0}
  };

  // output side: check each beat, then pick tready for the next cycle
  initial begin
    int hold_left;
    int seen_reqs;
    cmd_beat_t e;
    hold_left = 0;
    seen_reqs = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_cmds.size() == 0) begin
          $error("unexpected beat id %h data %h", m_axis_tdata[10:0], m_axis_tdata[74:11]);
          fails++;
        end else begin
          e = pending_cmds.pop_front();
          if (m_axis_tdata[10:0] !== e.id) begin
            $error("cmd_id expected %h actual %h", e.id, m_axis_tdata[10:0]);
            fails++;
          end
          if (m_axis_tdata[74:11] !== e.data) begin
            $error("cmd_data expected %h actual %h", e.data, m_axis_tdata[74:11]);
            fails++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last_of_run expected %b actual %b", e.last, m_axis_tlast);
            fails++;
          end
        end
      end
      if (hold_reqs != seen_reqs) begin
        seen_reqs = hold_reqs;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct(0));
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int n_prior;
    reset_shadow();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      n_prior = pending_cmds.size();
      send_item(dir_rows[k].kind, dir_rows[k].id, dir_rows[k].data);
      if (dir_rows[k].chk && (pending_cmds.size() <= n_prior
          || pending_cmds[n_prior].id != dir_rows[k].exp_id
          || pending_cmds[n_prior].data != dir_rows[k].exp_data)) begin
        $error("row %0d first command not as listed", k);
        fails++;
      end
    end
    drain();

    write_reg(RegAmplitude, 20'd1000000);
    write_reg(RegSpeedLimit, 20'hFFFFF);
    write_reg(RegStagger, 20'd0);
    mode = 0;
    repeat (90) random_item();
    drain();

    write_reg(RegAmplitude, 20'd0);
    write_reg(RegSpeedLimit, 20'd0);
    write_reg(RegStagger, 20'd3);
    write_reg(2'd3, 20'hFFFFF);
    mode = 1;
    repeat (30) random_item();
    // long output stall while ticks keep coming
    hold_reqs++;
    repeat (30) send_item(1'b0, 11'h0, 64'h0);
    repeat (50) random_item();
    drain();

    write_reg(RegAmplitude, 20'($urandom_range(1000000)));
    write_reg(RegSpeedLimit, 20'($urandom));
    write_reg(RegStagger, 20'hFFFF);
    mode = 2;
    repeat (90) random_item();
    drain();

    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
